// ----- sv/qrrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrrs_pkg
// Shared types, widths and status codes for the quadratic real-root solver.
// ----------------------------------------------------------------------------
package qrrs_pkg;

    // coefficient width, signed with 8 fraction bits
    localparam int COEF_WIDTH = 16;
    localparam int ROOT_WIDTH = 32;
    localparam int FRAC_SHIFT = 16;

    // discriminant, signed and magnitude
    localparam int DISC_W = 2 * COEF_WIDTH + 2;
    localparam int DMAG_W = DISC_W - 1;

    // square root: one result bit per stage
    localparam int SQRT_W = COEF_WIDTH + 1;
    localparam int RAD_W  = 2 * SQRT_W;
    localparam int SREM_W = SQRT_W + 3;

    // numerator -b +/- s and the division
    localparam int NUM_W  = COEF_WIDTH + 3;
    localparam int NMAG_W = NUM_W - 1;
    localparam int DIV_W  = COEF_WIDTH + 1;
    localparam int DVD_W  = NMAG_W + FRAC_SHIFT;
    localparam int DREM_W = DIV_W + 1;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_TWO   = 2'd0,
        ST_ONE   = 2'd1,
        ST_NONE  = 2'd2,
        ST_AZERO = 2'd3
    } root_status_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        root_status_t                 root_status;
        logic signed [ROOT_WIDTH-1:0] root_plus;
        logic signed [ROOT_WIDTH-1:0] root_minus;
        logic                         saturated;
    } roots_t;

    // classified item handed from front to back
    typedef struct packed {
        root_status_t                 status;
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic        [DMAG_W-1:0]     disc;
    } job_t;

endpackage

// ----- sv/quadratic_real_root_solver_top.sv -----
// ----------------------------------------------------------------------------
// quadratic_real_root_solver_top
// Real roots of a*x^2 + b*x + c from Q8.8 coefficients, roots in Q16.16.
// ----------------------------------------------------------------------------
// pipeline: 2 front stages, queue, 18 square-root stages, 1 numerator stage,
//   34 divider stages and the output register
// throughput: one item per cycle while the output is not stalled; the
//   bit-per-stage root and divider pipes set the latency, and the 4-entry
//   queue lets the front take a few more items while m_ready is low
// reset: aresetn synchronous active low clears all valid bits and the queue
module quadratic_real_root_solver_top import qrrs_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coef_t  s_data,
    output logic   m_valid,
    input  logic   m_ready,
    output roots_t m_data
);

    logic fq_valid;
    logic fq_ready;
    job_t fq_data;
    logic qb_valid;
    logic qb_ready;
    job_t qb_data;

    // accept and classify
    qrrs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    // decoupling queue
    qrrs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // root and division pipes
    qrrs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- sv/qrrs_front.sv -----
// ----------------------------------------------------------------------------
// qrrs_front
// Registers coefficients, forms the discriminant and classifies the item.
// ----------------------------------------------------------------------------
module qrrs_front import qrrs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  coef_t s_data,
    output logic  job_valid,
    input  logic  job_ready,
    output job_t  job_data
);

    logic                           adv;
    logic                           in_vld_reg;
    coef_t                          in_reg;
    logic                           pr_vld_reg;
    logic signed [COEF_WIDTH-1:0]   a_reg;
    logic signed [COEF_WIDTH-1:0]   b_reg;
    logic signed [2*COEF_WIDTH-1:0] bb_reg;
    logic signed [2*COEF_WIDTH-1:0] ac_reg;
    logic signed [DISC_W-1:0]       disc;

    // both stages move together while the last one is empty or the queue takes it
    assign adv     = !pr_vld_reg || job_ready;
    assign s_ready = adv;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            pr_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_valid;
            pr_vld_reg <= in_vld_reg;
        end
    end

    // input register, then the two products
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= s_data;
            a_reg  <= in_reg.coef_a;
            b_reg  <= in_reg.coef_b;
            bb_reg <= in_reg.coef_b * in_reg.coef_b;
            ac_reg <= in_reg.coef_a * in_reg.coef_c;
        end
    end

    // discriminant and classification
    always_comb begin
        disc            = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
        job_data.coef_a = a_reg;
        job_data.coef_b = b_reg;
        job_data.disc   = disc[DMAG_W-1:0];
        if (a_reg == '0) begin
            job_data.status = ST_AZERO;
        end else if (disc[DISC_W-1]) begin
            job_data.status = ST_NONE;
        end else if (disc == '0) begin
            job_data.status = ST_ONE;
        end else begin
            job_data.status = ST_TWO;
        end
    end

    assign job_valid = pr_vld_reg;

endmodule

// ----- sv/qrrs_queue.sv -----
// ----------------------------------------------------------------------------
// qrrs_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module qrrs_queue import qrrs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/qrrs_back.sv -----
// ----------------------------------------------------------------------------
// qrrs_back
// Pipelined square root, two pipelined dividers and the output register.
// ----------------------------------------------------------------------------
module qrrs_back import qrrs_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   job_valid,
    output logic   job_ready,
    input  job_t   job_data,
    output logic   m_valid,
    input  logic   m_ready,
    output roots_t m_data
);

    typedef struct packed {
        root_status_t                 status;
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
    } sq_meta_t;

    typedef struct packed {
        root_status_t status;
        logic         neg_p;
        logic         neg_m;
    } dv_meta_t;

    logic adv;

    logic                sq_vld_reg  [SQRT_W+1];
    sq_meta_t            sq_meta_reg [SQRT_W+1];
    logic [RAD_W-1:0]    sq_x_reg    [SQRT_W+1];
    logic [SREM_W-1:0]   sq_rem_reg  [SQRT_W+1];
    logic [SQRT_W-1:0]   sq_root_reg [SQRT_W+1];

    logic                dv_vld_reg   [DVD_W+1];
    dv_meta_t            dv_meta_reg  [DVD_W+1];
    logic [DIV_W-1:0]    dv_div_reg   [DVD_W+1];
    logic [DVD_W-1:0]    dv_qp_reg    [DVD_W+1];
    logic [DVD_W-1:0]    dv_qm_reg    [DVD_W+1];
    logic [DREM_W-1:0]   dv_rp_reg    [DVD_W+1];
    logic [DREM_W-1:0]   dv_rm_reg    [DVD_W+1];

    logic                m_valid_reg;
    roots_t              m_data_reg;

    // whole back pipe shifts when the output register is free
    assign adv       = !m_valid_reg || m_ready;
    assign job_ready = adv;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // one divider step: shift in a dividend bit, subtract if it fits
    function automatic logic [DREM_W+DVD_W-1:0] div_step(
        input logic [DREM_W-1:0] rem,
        input logic [DVD_W-1:0]  dvd,
        input logic [DIV_W-1:0]  dvs
    );
        logic [DREM_W-1:0] sh;
        logic              ge;
        sh = {rem[DREM_W-2:0], dvd[DVD_W-1]};
        ge = sh >= DREM_W'(dvs);
        return {ge ? sh - DREM_W'(dvs) : sh, dvd[DVD_W-2:0], ge};
    endfunction

    // clamp a signed quotient to the result range
    function automatic logic [ROOT_WIDTH:0] clamp(
        input logic [DVD_W-1:0] mag,
        input logic             neg
    );
        logic [DVD_W:0] lim;
        lim = (DVD_W+1)'(1) << (ROOT_WIDTH - 1);
        if (!neg && ({1'b0, mag} >= lim)) begin
            return {1'b1, 1'b0, {(ROOT_WIDTH-1){1'b1}}};
        end else if (neg && ({1'b0, mag} > lim)) begin
            return {1'b1, 1'b1, {(ROOT_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, ROOT_WIDTH'(-mag) & {ROOT_WIDTH{neg}}
                    | ROOT_WIDTH'(mag) & {ROOT_WIDTH{!neg}}};
        end
    endfunction

    // sqrt entry from the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= job_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_meta_reg[0] <= '{job_data.status, job_data.coef_a, job_data.coef_b};
            sq_x_reg[0]    <= RAD_W'(job_data.disc);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // square root stages, one root bit each
    for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
        logic [SREM_W-1:0] sh;
        logic [SREM_W-1:0] trial;
        logic              ge;

        always_comb begin
            sh    = {sq_rem_reg[k][SREM_W-3:0], sq_x_reg[k][RAD_W-1 -: 2]};
            trial = SREM_W'({sq_root_reg[k], 2'b01});
            ge    = sh >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_meta_reg[k+1] <= sq_meta_reg[k];
                sq_x_reg[k+1]    <= {sq_x_reg[k][RAD_W-3:0], 2'b00};
                sq_rem_reg[k+1]  <= ge ? sh - trial : sh;
                sq_root_reg[k+1] <= {sq_root_reg[k][SQRT_W-2:0], ge};
            end
        end
    end

    // numerators, signs and divisor magnitude
    logic signed [NUM_W-1:0]   num_p;
    logic signed [NUM_W-1:0]   num_m;
    logic signed [NUM_W-1:0]   s_ext;
    logic signed [NUM_W-1:0]   b_ext;
    logic signed [DIV_W:0]     a2;
    logic [NUM_W-1:0]          mag_p;
    logic [NUM_W-1:0]          mag_m;
    logic [DIV_W:0]            mag_a;
    sq_meta_t                  sq_last;

    always_comb begin
        sq_last = sq_meta_reg[SQRT_W];
        s_ext   = $signed(NUM_W'(sq_root_reg[SQRT_W]));
        b_ext   = NUM_W'(sq_last.coef_b);
        num_p   = s_ext - b_ext;
        num_m   = -s_ext - b_ext;
        a2      = (DIV_W+1)'(sq_last.coef_a) <<< 1;
        mag_p   = num_p[NUM_W-1] ? NUM_W'(-num_p) : NUM_W'(num_p);
        mag_m   = num_m[NUM_W-1] ? NUM_W'(-num_m) : NUM_W'(num_m);
        mag_a   = a2[DIV_W] ? (DIV_W+1)'(-a2) : (DIV_W+1)'(a2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= sq_vld_reg[SQRT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_meta_reg[0] <= '{sq_last.status,
                                num_p[NUM_W-1] ^ sq_last.coef_a[COEF_WIDTH-1],
                                num_m[NUM_W-1] ^ sq_last.coef_a[COEF_WIDTH-1]};
            dv_div_reg[0]  <= mag_a[DIV_W-1:0];
            dv_qp_reg[0]   <= {mag_p[NMAG_W-1:0], FRAC_SHIFT'(0)};
            dv_qm_reg[0]   <= {mag_m[NMAG_W-1:0], FRAC_SHIFT'(0)};
            dv_rp_reg[0]   <= '0;
            dv_rm_reg[0]   <= '0;
        end
    end

    // divider stages, one quotient bit per lane each
    for (genvar k = 0; k < DVD_W; k++) begin : g_div
        logic [DREM_W+DVD_W-1:0] st_p;
        logic [DREM_W+DVD_W-1:0] st_m;

        always_comb begin
            st_p = div_step(dv_rp_reg[k], dv_qp_reg[k], dv_div_reg[k]);
            st_m = div_step(dv_rm_reg[k], dv_qm_reg[k], dv_div_reg[k]);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_meta_reg[k+1] <= dv_meta_reg[k];
                dv_div_reg[k+1]  <= dv_div_reg[k];
                dv_rp_reg[k+1]   <= st_p[DREM_W+DVD_W-1 -: DREM_W];
                dv_qp_reg[k+1]   <= st_p[DVD_W-1:0];
                dv_rm_reg[k+1]   <= st_m[DREM_W+DVD_W-1 -: DREM_W];
                dv_qm_reg[k+1]   <= st_m[DVD_W-1:0];
            end
        end
    end

    // sign, clamp and status masking
    logic [ROOT_WIDTH:0] cl_p;
    logic [ROOT_WIDTH:0] cl_m;
    dv_meta_t            dv_last;
    roots_t              result;

    always_comb begin
        dv_last = dv_meta_reg[DVD_W];
        cl_p    = clamp(dv_qp_reg[DVD_W], dv_last.neg_p);
        cl_m    = clamp(dv_qm_reg[DVD_W], dv_last.neg_m);
        result.root_status = dv_last.status;
        if (dv_last.status == ST_TWO || dv_last.status == ST_ONE) begin
            result.root_plus  = cl_p[ROOT_WIDTH-1:0];
            result.root_minus = cl_m[ROOT_WIDTH-1:0];
            result.saturated  = cl_p[ROOT_WIDTH] | cl_m[ROOT_WIDTH];
        end else begin
            result.root_plus  = '0;
            result.root_minus = '0;
            result.saturated  = 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_vld_reg[DVD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= result;
        end
    end

endmodule

// ----- test/quadratic_real_root_solver_top_test.sv -----
// ----------------------------------------------------------------------------
// quadratic_real_root_solver_top_test
// Drives coefficient triples into the root solver with random gaps on both
// channels, predicts the roots and status in fixed point, and compares every
// result in order.
// ----------------------------------------------------------------------------
module quadratic_real_root_solver_top_test;
    import qrrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    coef_t  s_data;
    logic   m_valid;
    logic   m_ready;
    roots_t m_data;

    roots_t roots_expected[$];
    int     mismatch_count;
    int     triples_sent;
    int     roots_checked;

    quadratic_real_root_solver_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // isqrt floor of a non-negative value
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned bit_val;
        r = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > x) bit_val >>= 2;
        while (bit_val != 0) begin
            if (x >= r + bit_val) begin
                x -= r + bit_val;
                r = (r >> 1) + bit_val;
            end else begin
                r >>= 1;
            end
            bit_val >>= 2;
        end
        return r;
    endfunction

    // quotient truncated toward zero, then clamped to 32 bits
    function automatic logic signed [31:0] root_quotient(longint num, longint a,
                                                         ref bit clamped);
        longint q;
        q = (num * 65536) / (2 * a);
        if (q > 64'sd2147483647) begin
            clamped = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -64'sd2147483648) begin
            clamped = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    // expected roots for one coefficient triple
    function automatic roots_t solve_roots(coef_t coefs);
        roots_t r;
        longint a, b, c, disc, s;
        bit clamped;
        a = coefs.coef_a;
        b = coefs.coef_b;
        c = coefs.coef_c;
        clamped = 1'b0;
        r = '0;
        if (a == 0) begin
            r.root_status = ST_AZERO;
        end else begin
            disc = b * b - 4 * a * c;
            if (disc < 0) begin
                r.root_status = ST_NONE;
            end else begin
                s = longint'(floor_sqrt(disc));
                r.root_status = (disc == 0) ? ST_ONE : ST_TWO;
                r.root_plus   = root_quotient(-b + s, a, clamped);
                r.root_minus  = root_quotient(-b - s, a, clamped);
            end
        end
        r.saturated = clamped;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        mismatch_count++;
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 roots_checked, field, got, want);
    endtask

    // one coefficient transfer; valid stays high across back-to-back items
    task automatic send_triple(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        coef_t coefs;
        int gap;
        coefs.coef_a = a;
        coefs.coef_b = b;
        coefs.coef_c = c;
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= coefs;
        roots_expected.push_back(solve_roots(coefs));
        triples_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side: random stalls
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 1);
            end
            @(posedge aclk);
        end
    end

    // result checker
    initial begin
        roots_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (roots_expected.size() == 0) begin
                    mismatch_count++;
                    $display("result transfer with nothing expected");
                end else begin
                    want = roots_expected.pop_front();
                    if (m_data.root_status !== want.root_status)
                        report_mismatch("root_status", m_data.root_status,
                                        want.root_status);
                    if (m_data.root_plus !== want.root_plus)
                        report_mismatch("root_plus", m_data.root_plus, want.root_plus);
                    if (m_data.root_minus !== want.root_minus)
                        report_mismatch("root_minus", m_data.root_minus,
                                        want.root_minus);
                    if (m_data.saturated !== want.saturated)
                        report_mismatch("saturated", m_data.saturated, want.saturated);
                end
                roots_checked++;
            end
        end
    end

    task automatic test_extremes();
        send_triple(16'h0000, 16'h1234, 16'h0100);  // a is zero
        send_triple(16'h0000, 16'h0000, 16'h0000);
        send_triple(16'h0100, 16'h0000, 16'h0100);  // no real roots
        send_triple(16'h0100, 16'h0200, 16'h0100);  // one root
        send_triple(16'h0100, 16'h0000, 16'hff00);  // two roots
        send_triple(16'h0100, 16'hfd00, 16'h0200);
        send_triple(16'h0001, 16'h7fff, 16'h0000);  // large negative root, not clamped
        send_triple(16'h0001, 16'h8000, 16'h0000);  // clamp high
        send_triple(16'hffff, 16'h8000, 16'h7fff);
        send_triple(16'h7fff, 16'h7fff, 16'h8000);
        send_triple(16'h8000, 16'h8000, 16'h7fff);
        send_triple(16'h8000, 16'h7fff, 16'h8000);
        send_triple(16'h7fff, 16'h8000, 16'h7fff);
        send_triple(16'hffff, 16'hffff, 16'hffff);
        send_triple(16'h8000, 16'h0000, 16'h0000);  // one root at zero
        send_triple(16'h0001, 16'h0001, 16'h0000);
        send_triple(16'hff00, 16'h0400, 16'h0400);
    endtask

    task automatic test_random();
        logic [15:0] a, b, c;
        logic [15:0] r;
        for (int i = 0; i < 1000; i++) begin
            a = $urandom();
            b = $urandom();
            c = $urandom();
            case ($urandom_range(0, 9))
                0: a = '0;
                1: begin
                    // near perfect square: a(x-r)^2 style, discriminant zero when 4a divides b*b, else positive
                    r = $urandom_range(0, 255);
                    a = $urandom_range(1, 64);
                    b = 16'(-2 * int'(a) * int'(r) / 256);
                    c = 16'(int'($signed(b)) * int'($signed(b)) / (4 * int'(a)));
                end
                2: begin
                    a = $urandom_range(1, 2);
                end
                3: begin
                    a = 16'($signed($urandom_range(0, 1023)) - 512);
                    b = 16'($signed($urandom_range(0, 4095)) - 2048);
                    c = 16'($signed($urandom_range(0, 4095)) - 2048);
                end
                default: ;
            endcase
            send_triple(a, b, c);
        end
    endtask

    // stimulus
    initial begin
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        mismatch_count = 0;
        triples_sent = 0;
        roots_checked = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_random();
        s_valid <= 1'b0;
        while (roots_expected.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("sent %0d coefficient triples, checked %0d results", triples_sent,
                 roots_checked);
        $display("covered zero a, no, one and two roots, clamping and random gaps");
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout after %0d results", roots_checked);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- quadratic_real_root_solver_top.f -----
sv/qrrs_pkg.sv
sv/qrrs_front.sv
sv/qrrs_queue.sv
sv/qrrs_back.sv
sv/quadratic_real_root_solver_top.sv
test/quadratic_real_root_solver_top_test.sv
